@@ design/vln_pkg.sv @@
// vln_pkg: shared types and constants for the vector L2 normalizer.
// Used by vector_l2_normalizer_unit; no dependencies.
package vln_pkg;

	localparam int VLN_MAX_LEN = 16;      // default vector buffer depth
	localparam int VAL_W       = 16;      // element and result width (Q8.8 / Q1.14)
	localparam int LEN_W       = 5;       // vector_length register width
	localparam int LEN_RESET   = 4;       // vector_length after reset
	localparam int NORM_W      = 18;      // norm width, Q10.8
	localparam int SQ_W        = 2 * VAL_W;
	localparam int SUM_W       = 35;      // square sum width, Q19.16 (wraps)
	localparam int RAD_W       = 2 * NORM_W; // radicand padded to whole bit pairs
	localparam int REM_W       = 21;      // shared compare/subtract width
	localparam int SQRT_STEPS  = NORM_W;  // one root bit per step
	localparam int FRAC_SHIFT  = 14;
	localparam int DVD_W       = VAL_W + FRAC_SHIFT; // dividend mag << 14
	localparam int DIV_STEPS   = DVD_W;   // one quotient bit per step
	localparam int STEP_W      = 5;
	localparam int ONE_Q14     = 16384;

	typedef enum logic [2:0] {
		ST_IDLE,   // waiting for an element beat
		ST_ACC,    // add the element's square to the running sum
		ST_SQRT,   // digit-by-digit square root of the sum
		ST_READ,   // issue buffer read for element k
		ST_LOAD,   // capture element k, set up the divide
		ST_DIV,    // restoring divide, one bit a cycle
		ST_OUT     // hand result k to the output register
	} vln_state_t;

endpackage

@@ design/vector_l2_normalizer_unit.sv @@
// vector_l2_normalizer_unit: top level of the vector L2 normalizer.
// Depends on vln_pkg, vln_ram and vln_cs_unit.
//
// Element beats (signed Q8.8) are taken one at a time and kept in a small
// buffer RAM while their squares are summed. Once vector_length elements are
// in (0 acts as 1, anything above MAX_LEN as MAX_LEN), the floor square root of
// the sum gives the norm (unsigned Q10.8), and then every element is divided by
// the norm and sent out as signed Q1.14, truncated toward zero and clamped to
// +/-1.0, together with its index, the norm, a zero-norm flag and a last mark.
// A zero norm gives zero results with zero_norm set. One compare/subtract unit
// does all the heavy lifting: first the root, then the divide for each element
// (skipped on zero norm). elem_stall is high for the accumulate cycle after
// every element, and from the last element of a vector until its final result
// has been loaded into the output register; a result waiting on res_stall does
// not block the next element. Writing vector_length drops any partial vector;
// write it only while the block is idle.
module vector_l2_normalizer_unit
	import vln_pkg::*;
#(
	parameter int MAX_LEN = VLN_MAX_LEN,
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     vector_length_we,
	input  logic [LEN_W-1:0]         vector_length,
	// element channel
	input  logic                     elem_valid,
	output logic                     elem_stall,
	input  logic signed [VAL_W-1:0]  element_value,
	// result channel
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic signed [VAL_W-1:0]  normalised_value,
	output logic [IDX_W-1:0]         element_index,
	output logic [NORM_W-1:0]        vector_norm,
	output logic                     zero_norm,
	output logic                     last_of_vector
);

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int LW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	vln_state_t state_q, state_d;

	// control state
	logic [LEN_W-1:0]  len_q;
	logic [CNT_W-1:0]  cnt_q;      // elements taken in this vector
	logic [CNT_W-1:0]  k_q;        // element being emitted
	logic [SUM_W-1:0]  sum_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	// datapath
	logic [VAL_W-1:0]  mag_q;
	logic [RAD_W-1:0]  rad_q;
	logic [NORM_W-1:0] root_q;
	logic [NORM_W-1:0] norm_q;
	logic [NORM_W:0]   rem_q;
	logic [DVD_W-1:0]  dvd_q;      // dividend in, quotient out
	logic              neg_q;

	// output register
	logic [VAL_W-1:0]  res_val_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [NORM_W-1:0] res_norm_q;
	logic              res_zero_q;
	logic              res_last_q;

	logic [CNT_W-1:0]  len_act;
	logic [LW-1:0]     len_x;
	logic              elem_acc, res_acc, out_load, last_k, norm_zero;
	logic [SQ_W-1:0]   sq;
	logic [SUM_W-1:0]  sum_next;
	logic [REM_W-1:0]  cs_a, cs_b, cs_diff;
	logic              cs_ge;
	logic [VAL_W-1:0]  ram_rdata, emag;
	logic              ram_re;
	logic [VAL_W-1:0]  q_clamp, q_signed;

	// effective length: 0 acts as 1, clip at MAX_LEN
	assign len_x = LW'(len_q);
	always_comb begin
		if (len_q == '0) begin
			len_act = CNT_W'(1);
		end else if (len_x > LW'(MAX_LEN)) begin
			len_act = CNT_W'(MAX_LEN);
		end else begin
			len_act = CNT_W'(len_x);
		end
	end

	assign elem_acc  = (state_q == ST_IDLE) && elem_valid;
	assign elem_stall = (state_q != ST_IDLE);
	assign res_acc   = out_valid_q && !res_stall;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !res_stall);
	assign last_k    = (k_q == len_act - CNT_W'(1));
	assign norm_zero = (norm_q == '0);

	assign sq       = mag_q * mag_q;
	assign sum_next = sum_q + SUM_W'(sq);

	// element buffer
	vln_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_LEN)
	) u_ram (
		.clk   (clk),
		.we    (elem_acc),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (element_value),
		.re    (ram_re),
		.raddr (k_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign ram_re = (state_q == ST_READ);

	// shared compare/subtract: root trial in ST_SQRT, divisor otherwise
	always_comb begin
		if (state_q == ST_SQRT) begin
			cs_a = REM_W'({rem_q, rad_q[RAD_W-1 -: 2]});
			cs_b = REM_W'({root_q, 2'b01});
		end else begin
			cs_a = REM_W'({rem_q[NORM_W-1:0], dvd_q[DVD_W-1]});
			cs_b = REM_W'(norm_q);
		end
	end

	vln_cs_unit #(
		.W (REM_W)
	) u_cs (
		.minuend    (cs_a),
		.subtrahend (cs_b),
		.diff       (cs_diff),
		.ge         (cs_ge)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (elem_valid) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = (cnt_q == len_act) ? ST_SQRT : ST_IDLE;
			end
			ST_SQRT: begin
				if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: state_d = norm_zero ? ST_OUT : ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = last_k ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_W'(LEN_RESET);
			cnt_q       <= '0;
			k_q         <= '0;
			sum_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (vector_length_we) begin
				len_q <= vector_length;
				cnt_q <= '0;
				sum_q <= '0;
			end else if (elem_acc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (state_q == ST_ACC) begin
				sum_q <= sum_next;
			end else if (out_load && last_k) begin
				cnt_q <= '0;
				sum_q <= '0;
			end

			if (state_q == ST_ACC) begin
				k_q <= '0;
			end else if (out_load) begin
				k_q <= k_q + CNT_W'(1);
			end

			if (state_q == ST_SQRT || state_q == ST_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// element magnitude; -32768 maps to 32768, which still fits 16 bits
	assign emag = ram_rdata[VAL_W-1] ? (~ram_rdata + VAL_W'(1)) : ram_rdata;

	// clamp quotient to 1.0, force zero on zero norm, restore sign
	always_comb begin
		if (norm_zero) begin
			q_clamp = '0;
		end else if (dvd_q > DVD_W'(ONE_Q14)) begin
			q_clamp = VAL_W'(ONE_Q14);
		end else begin
			q_clamp = dvd_q[VAL_W-1:0];
		end
		q_signed = neg_q ? (~q_clamp + VAL_W'(1)) : q_clamp;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (elem_acc) begin
			mag_q <= element_value[VAL_W-1] ? (~element_value + VAL_W'(1))
			                                : element_value;
		end

		unique case (state_q)
			ST_ACC: begin
				rad_q  <= RAD_W'(sum_next);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= cs_ge ? cs_diff[NORM_W:0] : cs_a[NORM_W:0];
				root_q <= {root_q[NORM_W-2:0], cs_ge};
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
					norm_q <= {root_q[NORM_W-2:0], cs_ge};
				end
			end
			ST_LOAD: begin
				dvd_q <= {emag, FRAC_SHIFT'(0)};
				neg_q <= ram_rdata[VAL_W-1];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= cs_ge ? cs_diff[NORM_W:0] : cs_a[NORM_W:0];
				dvd_q <= {dvd_q[DVD_W-2:0], cs_ge};
			end
			ST_IDLE, ST_READ, ST_OUT: begin
			end
			default: begin
			end
		endcase

		if (out_load) begin
			res_val_q  <= q_signed;
			res_idx_q  <= k_q[IDX_W-1:0];
			res_norm_q <= norm_q;
			res_zero_q <= norm_zero;
			res_last_q <= last_k;
		end
	end

	assign res_valid        = out_valid_q;
	assign normalised_value = res_val_q;
	assign element_index    = res_idx_q;
	assign vector_norm      = res_norm_q;
	assign zero_norm        = res_zero_q;
	assign last_of_vector   = res_last_q;

endmodule

@@ design/vln_ram.sv @@
// vln_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module vln_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/vln_cs_unit.sv @@
// vln_cs_unit: shared compare-and-subtract step used by both the square root
// and the divider. No dependencies.
module vln_cs_unit #(
	parameter int W = 21
) (
	input  logic [W-1:0] minuend,
	input  logic [W-1:0] subtrahend,
	output logic [W-1:0] diff,
	output logic         ge
);

	logic [W:0] wide;

	assign wide = {1'b0, minuend} - {1'b0, subtrahend};
	assign diff = wide[W-1:0];
	assign ge   = ~wide[W];   // no borrow: minuend >= subtrahend

endmodule
